>>> hw/rtl/kat_pkg.sv
package kat_pkg;

    localparam int SPEED_W  = 14;
    localparam int ANGLE_W  = 13;
    localparam int ROW_W    = 7;
    localparam int COL_W    = 5;
    localparam int VALUE_W  = 16;
    localparam int FRAC_W   = 7;
    localparam int WEIGHT_W = 13;
    localparam int SUM_W    = 29;
    localparam int QUOT_W   = 17;
    localparam int DIVY_W   = 21;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Speed and angle are in 1/16 units, so one grid step of 5 is 80.
    localparam logic [SPEED_W-1:0] SPEED_LOW  = 14'd3120;
    localparam logic [SPEED_W-1:0] SPEED_HIGH = 14'd10400;
    localparam logic [SPEED_W-1:0] SLOW_SPEED = 14'd160;
    localparam logic [10:0]        ANGLE_HIGH = 11'd1280;
    localparam int GRID_STEP  = 80;
    localparam int GRID_CEIL  = GRID_STEP - 1;
    // floor(y / 5) == (y * 205) >> 10 for every y below 1024.
    localparam int DIV5_MUL   = 205;
    localparam int DIV5_SHIFT = 10;
    localparam int ROUND_HALF = 3200;
    // floor(y * RECIP_25 >> 25) is floor(y / 25) or one below it.
    localparam int RECIP_25    = 1342177;
    localparam int RECIP_SHIFT = 25;
    localparam int DIVISOR_25  = 25;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                      lookup;
        logic                      force_zero;
        logic                      negate;
        logic                      write_ok;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          column;
        logic [FRAC_W-1:0]         dx;
        logic [FRAC_W-1:0]         dy;
        logic signed [VALUE_W-1:0] value;
    } kat_item_t;

endpackage

>>> hw/rtl/kat_if.sv
interface kat_item_if import kat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [SPEED_W-1:0]        ball_speed;
    logic signed [ANGLE_W-1:0] angle_difference;
    logic [ROW_W-1:0]          entry_row;
    logic [COL_W-1:0]          entry_column;
    logic signed [VALUE_W-1:0] entry_value;

    modport source (
        output valid, command, ball_speed, angle_difference,
               entry_row, entry_column, entry_value,
        input  ready
    );
    modport sink (
        input  valid, command, ball_speed, angle_difference,
               entry_row, entry_column, entry_value,
        output ready
    );
endinterface

interface kat_result_if import kat_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] compensation;
    logic                      was_lookup;

    modport source (
        output valid, compensation, was_lookup,
        input  ready
    );
    modport sink (
        input  valid, compensation, was_lookup,
        output ready
    );
endinterface

>>> hw/rtl/kat_front.sv
module kat_front import kat_pkg::*; #(
    parameter int ROW_COUNT    = 128,
    parameter int COLUMN_COUNT = 32
) (
    kat_item_if.sink  item,
    input  logic      bypass,
    input  logic      q_full,
    output logic      q_push,
    output kat_item_t q_item
);

    logic [ANGLE_W-1:0] mag;
    logic [10:0]        a_clamp;
    logic [10:0]        col_sum;
    logic [14:0]        col_div;
    logic [COL_W-1:0]   col_raw;
    logic [COL_W-1:0]   column;
    logic [10:0]        col_base;
    logic [SPEED_W-1:0] s_clamp;
    logic [12:0]        s_off;
    logic [12:0]        row_sum;
    logic [16:0]        row_div;
    logic [ROW_W-1:0]   row_raw;
    logic [ROW_W-1:0]   row;
    logic [12:0]        row_base;
    logic               is_lookup;

    assign item.ready = !q_full;
    assign q_push     = item.valid && !q_full;
    assign is_lookup  = (item.command == CMD_LOOKUP);

    // Grid column: ceil(a / 80) with a floor of one, then the offset inside the cell.
    always_comb
    begin
        mag      = item.angle_difference[ANGLE_W-1] ? ANGLE_W'(-item.angle_difference)
                                                    : ANGLE_W'(item.angle_difference);
        a_clamp  = (mag > ANGLE_W'(ANGLE_HIGH)) ? ANGLE_HIGH : mag[10:0];
        col_sum  = a_clamp + 11'(GRID_CEIL);
        col_div  = 15'(col_sum[10:4]) * 15'(DIV5_MUL);
        col_raw  = col_div[DIV5_SHIFT +: COL_W];
        column   = (col_raw == '0) ? COL_W'(1) : col_raw;
        col_base = 11'(column - COL_W'(1)) * 11'(GRID_STEP);
    end

    always_comb
    begin
        if (item.ball_speed < SPEED_LOW)
        begin
            s_clamp = SPEED_LOW;
        end
        else if (item.ball_speed > SPEED_HIGH)
        begin
            s_clamp = SPEED_HIGH;
        end
        else
        begin
            s_clamp = item.ball_speed;
        end
        s_off    = 13'(s_clamp - SPEED_LOW);
        row_sum  = s_off + 13'(GRID_CEIL);
        row_div  = 17'(row_sum[12:4]) * 17'(DIV5_MUL);
        row_raw  = row_div[DIV5_SHIFT +: ROW_W];
        row      = (row_raw == '0) ? ROW_W'(1) : row_raw;
        row_base = 13'(row - ROW_W'(1)) * 13'(GRID_STEP);
    end

    always_comb
    begin
        q_item.lookup     = is_lookup;
        q_item.force_zero = (item.ball_speed < SLOW_SPEED) || bypass;
        q_item.negate     = item.angle_difference[ANGLE_W-1] || (item.angle_difference == '0);
        q_item.write_ok   = ({2'b00, item.entry_row} < 9'(ROW_COUNT))
                         && ({2'b00, item.entry_column} < 7'(COLUMN_COUNT));
        q_item.row        = is_lookup ? row : item.entry_row;
        q_item.column     = is_lookup ? column : item.entry_column;
        q_item.dx         = FRAC_W'(a_clamp - col_base);
        q_item.dy         = FRAC_W'(s_off - row_base);
        q_item.value      = item.entry_value;
    end

endmodule

>>> hw/rtl/kat_queue.sv
module kat_queue import kat_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  kat_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output kat_item_t pop_item
);

    kat_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/kat_back.sv
module kat_back import kat_pkg::*; #(
    parameter int ROW_COUNT    = 128,
    parameter int COLUMN_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  kat_item_t   q_item,
    output logic        q_pop,
    kat_result_if.source result
);

    localparam int DEPTH  = ROW_COUNT * COLUMN_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_SEND = 3'd4;
    localparam logic [2:0] LAST_STEP = 3'd5;

    logic signed [VALUE_W-1:0] comp_mem [DEPTH];

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [2:0]                step_reg;
    logic [2:0]                step_next;
    kat_item_t                 cur_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [WEIGHT_W-1:0]       weight_reg;
    logic                      rd_vld_reg;
    logic signed [SUM_W-1:0]   prod_reg;
    logic                      prod_vld_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic [DIVY_W-1:0]         ydiv_reg;
    logic [QUOT_W-1:0]         q0_reg;
    logic                      sum_neg_reg;
    logic signed [VALUE_W-1:0] res_value_reg;
    logic signed [VALUE_W-1:0] res_value_next;
    logic                      res_lookup_reg;
    logic                      res_lookup_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] out_comp_reg;
    logic                      out_lookup_reg;

    logic                      issue;
    logic [1:0]                corner;
    logic [ROW_W-1:0]          row_sel;
    logic [COL_W-1:0]          col_sel;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      mem_we;
    logic [FRAC_W-1:0]         wx;
    logic [FRAC_W-1:0]         wy;
    logic [WEIGHT_W-1:0]       weight;
    logic signed [SUM_W-1:0]   data_ext;
    logic signed [SUM_W-1:0]   weight_ext;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W-1:0]          rounded;
    logic [DIVY_W-1:0]         ydiv;
    logic [41:0]               recip_prod;
    logic [DIVY_W-1:0]         remainder;
    logic [QUOT_W-1:0]         quotient;
    logic [QUOT_W-1:0]         neg_quot;
    logic                      load_out;
    logic                      start_look;

    // One corner of the cell per read: bit 0 picks the right column, bit 1 the upper row.
    assign issue   = (state_reg == S_LOOK) && (step_reg < 3'd4);
    assign corner  = step_reg[1:0];
    assign row_sel = cur_reg.row - ROW_W'(1) + ROW_W'(corner[1]);
    assign col_sel = cur_reg.column - COL_W'(1) + COL_W'(corner[0]);
    assign rd_addr = ADDR_W'(row_sel) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(col_sel);
    assign wr_addr = ADDR_W'(q_item.row) * ADDR_W'(COLUMN_COUNT) + ADDR_W'(q_item.column);
    assign wx      = corner[0] ? cur_reg.dx : FRAC_W'(GRID_STEP) - cur_reg.dx;
    assign wy      = corner[1] ? cur_reg.dy : FRAC_W'(GRID_STEP) - cur_reg.dy;
    assign weight  = WEIGHT_W'(wx) * WEIGHT_W'(wy);

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign mem_we     = q_pop && !q_item.lookup && q_item.write_ok;
    assign start_look = q_pop && q_item.lookup && !q_item.force_zero;
    assign load_out   = (state_reg == S_SEND) && (!out_valid_reg || result.ready);

    assign data_ext   = SUM_W'(rd_data_reg);
    assign weight_ext = SUM_W'({1'b0, weight_reg});

    // Rounding divide by 6400: the low 8 bits drop by shift, the /25 by reciprocal.
    always_comb
    begin
        sum_mag    = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
        rounded    = sum_mag + SUM_W'(ROUND_HALF);
        ydiv       = rounded[SUM_W-1:8];
        recip_prod = 42'(ydiv) * 42'(RECIP_25);
        remainder  = ydiv_reg - DIVY_W'(q0_reg) * DIVY_W'(DIVISOR_25);
        quotient   = (remainder >= DIVY_W'(DIVISOR_25)) ? q0_reg + 1'b1 : q0_reg;
        neg_quot   = -quotient;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        res_value_next  = res_value_reg;
        res_lookup_next = res_lookup_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    step_next       = '0;
                    res_value_next  = '0;
                    res_lookup_next = q_item.lookup;
                    state_next      = start_look ? S_LOOK : S_SEND;
                end
            end
            S_LOOK:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (sum_neg_reg ^ cur_reg.negate)
                begin
                    res_value_next = VALUE_W'(neg_quot);
                end
                else if (quotient > QUOT_W'(32767))
                begin
                    res_value_next = VALUE_W'(32767);
                end
                else
                begin
                    res_value_next = VALUE_W'(quotient);
                end
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_vld_reg    <= issue;
            prod_vld_reg  <= rd_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            comp_mem[wr_addr] <= q_item.value;
        end
        rd_data_reg <= comp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        weight_reg     <= weight;
        prod_reg       <= data_ext * weight_ext;
        res_value_reg  <= res_value_next;
        res_lookup_reg <= res_lookup_next;
        if (start_look)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (state_reg == S_DIV1)
        begin
            ydiv_reg    <= ydiv;
            q0_reg      <= recip_prod[RECIP_SHIFT +: QUOT_W];
            sum_neg_reg <= acc_reg[SUM_W-1];
        end
        if (load_out)
        begin
            out_comp_reg   <= res_value_reg;
            out_lookup_reg <= res_lookup_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.compensation = out_comp_reg;
    assign result.was_lookup   = out_lookup_reg;

endmodule

>>> hw/rtl/kick_angle_table_compensation.sv
// Kick angle compensation by bilinear lookup in a speed by angle table.
// Items arrive on the item channel; a beat with command 0 writes one table
// entry, a beat with command 1 looks up a compensation angle. Every item
// gives exactly one beat on the result channel, in order: a write returns
// zero with was_lookup low, a lookup returns the blended angle.
// The front end clamps and grids the inputs in the cycle of acceptance and
// places the item in a two-entry queue. The back end pops one item at a time:
// a write, or a lookup forced to zero by a slow ball or bypass, goes straight
// to the send state; a blended lookup first makes the four reads of the table
// memory, plus the multiply, accumulate and two-step rounding divide.
// The bypass bit is written through cfg_write_enable and cfg_write_data. The
// user must write it only while the block is idle; the block does not enforce
// this. Reset clears bypass, the queue and the output register; the table
// memory is not cleared and holds undefined data until written.
// When the receiver stalls, the result stays in the output register, the
// back end waits with the next result, and the queue fills; then item.ready
// drops until the receiver takes a beat.
module kick_angle_table_compensation import kat_pkg::*; #(
    parameter int ROW_COUNT    = 128,
    parameter int COLUMN_COUNT = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_enable,
    input  logic         cfg_write_data,
    kat_item_if.sink     item,
    kat_result_if.source result
);

    logic      bypass_reg;
    logic      bypass_next;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    kat_item_t front_item;
    kat_item_t back_item;

    assign bypass_next = cfg_write_enable ? cfg_write_data : bypass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else
        begin
            bypass_reg <= bypass_next;
        end
    end

    kat_front #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_front (
        .item   (item),
        .bypass (bypass_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (front_item)
    );

    kat_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (back_item)
    );

    kat_back #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (back_item),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule
